>>> rtl/ghacc_pkg.sv
// Shared types and the GF(2^128) multiply for the GHASH accumulator.
// No dependencies; imported by ghash_accumulator and its checker.
`timescale 1ns / 1ps

package ghacc_pkg;

  localparam int unsigned HALF_W  = 64;
  localparam int unsigned BLOCK_W = 2 * HALF_W;
  localparam int unsigned PROD_W  = 2 * BLOCK_W - 1;
  localparam int unsigned FOLD_W  = BLOCK_W + 6;
  localparam int unsigned ADDR_W  = 4;

  // Register index as seen on the address bit that selects the key half.
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef struct packed {
    logic [HALF_W-1:0] block_high;
    logic [HALF_W-1:0] block_low;
    logic              restart;
  } ghacc_in_t;

  typedef struct packed {
    logic [HALF_W-1:0] hash_high;
    logic [HALF_W-1:0] hash_low;
  } ghacc_out_t;

  // GCM multiply X * H. GCM numbers coefficients from the MSB of byte 0, so
  // both operands are bit-reversed into plain polynomial order, multiplied
  // carry-less, reduced by x^128 + x^7 + x^2 + x + 1 and reversed back.
  function automatic logic [BLOCK_W-1:0] gf128_mul(input logic [BLOCK_W-1:0] x,
                                                   input logic [BLOCK_W-1:0] h);
    logic [BLOCK_W-1:0]  a;
    logic [BLOCK_W-1:0]  b;
    logic [PROD_W-1:0]   c;
    logic [FOLD_W-1:0]   hi;
    logic [FOLD_W-1:0]   r1;
    logic [BLOCK_W-1:0]  top;
    logic [BLOCK_W-1:0]  r2;
    logic [BLOCK_W-1:0]  res;
    for (int i = 0; i < BLOCK_W; i++) begin
      a[i] = x[BLOCK_W-1-i];
      b[i] = h[BLOCK_W-1-i];
    end
    // Each partial row is independent; synthesis builds one XOR tree per bit.
    c = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      if (a[i]) begin
        c = c ^ ({{(PROD_W-BLOCK_W){1'b0}}, b} << i);
      end
    end
    // First fold: x^128 is replaced by x^7 + x^2 + x + 1.
    hi = {{(FOLD_W-(PROD_W-BLOCK_W)){1'b0}}, c[PROD_W-1:BLOCK_W]};
    r1 = {{(FOLD_W-BLOCK_W){1'b0}}, c[BLOCK_W-1:0]} ^ hi ^ (hi << 1) ^ (hi << 2) ^ (hi << 7);
    // Second fold for the few bits the first one pushed above x^127.
    top = {{(2*BLOCK_W-FOLD_W){1'b0}}, r1[FOLD_W-1:BLOCK_W]};
    r2  = r1[BLOCK_W-1:0] ^ top ^ (top << 1) ^ (top << 2) ^ (top << 7);
    for (int i = 0; i < BLOCK_W; i++) begin
      res[i] = r2[BLOCK_W-1-i];
    end
    return res;
  endfunction

endpackage

>>> rtl/ghash_accumulator.sv
// GHASH accumulator top level: APB key registers, input stage, GF(2^128)
// multiply-accumulate and result register. Depends on ghacc_pkg.
`timescale 1ns / 1ps

// The block absorbs one 128-bit word per clock while results are taken, and
// returns the running GHASH value after every word. An accepted word lands in
// an input register; when the result register is empty or being emptied, it
// is XORed into the accumulator (or into zero when restart is set) and
// multiplied by the hash subkey H in one pass of XOR logic, and the product
// is captured in the result register, which is also the accumulator.
// out_valid is registered together with that result. With out_ready high the
// sustained rate is one word per cycle, set by the combinational multiply
// that closes the accumulator feedback loop. The input side keeps accepting
// while a result waits, as long as the input register is empty or can move
// forward; with out_ready held low the block holds one result and one
// pending word before in_ready drops. H is written through the APB port as
// two 64-bit halves at byte addresses 0x0 (high) and 0x8 (low); only address
// bit 3 is decoded, and both halves read back. Write the key only while the
// block is idle. After reset H and the accumulator are zero, so every result
// reads zero until a key is loaded.
module ghash_accumulator
  import ghacc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ghacc_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ghacc_out_t            out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [HALF_W-1:0]     pwdata,
  output logic [HALF_W-1:0]     prdata,
  output logic                  pready
);

  // Hash subkey halves.
  logic [HALF_W-1:0]  key_high_r;
  logic [HALF_W-1:0]  key_low_r;

  // Input stage.
  logic               s1_valid_r;
  ghacc_in_t          s1_data_r;

  // Result register; it doubles as the accumulator.
  logic               out_valid_r;
  logic [BLOCK_W-1:0] hash_r;
  logic [BLOCK_W-1:0] hash_nxt;

  logic               cfg_write;
  logic               advance;
  logic [BLOCK_W-1:0] sum;

  // The register file is written in the access phase of a write.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[3] == REG_KEY_LOW) ? key_low_r : key_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_KEY_LOW:  key_low_r  <= pwdata;
        default:      key_high_r <= key_high_r;
      endcase
    end
  end

  // The input word moves on whenever the result register is empty or is
  // being emptied in this cycle, which keeps one word per cycle flowing.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Restart discards the previous accumulator before the new word is added.
  // The accumulator is only ever updated when a word advances, so the next
  // word in line always sees the value left by its predecessor.
  assign sum      = (s1_data_r.restart ? '0 : hash_r) ^
                    {s1_data_r.block_high, s1_data_r.block_low};
  assign hash_nxt = gf128_mul(sum, {key_high_r, key_low_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hash_r      <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        hash_r      <= hash_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.hash_high = hash_r[BLOCK_W-1:HALF_W];
  assign out_data.hash_low  = hash_r[HALF_W-1:0];

endmodule

>>> rtl/ghacc_checker.sv
// Port-level checker for ghash_accumulator and the bind that attaches it.
// Depends on ghacc_pkg and on the ports of ghash_accumulator.
`timescale 1ns / 1ps

module ghacc_checker
  import ghacc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ghacc_out_t        out_data,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [HALF_W-1:0] pwdata,
  input logic [HALF_W-1:0] prdata,
  input logic              pready
);

  // A result held back by the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A fresh result follows an accepted word, which passes through the input
  // register and then into the result register.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without an accepted word");

  // A consumer that takes results never stalls the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A key half reads back what was last written to it.
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(psel && penable && pwrite && pready) &&
    (paddr[3] == $past(paddr[3])) && !pwrite |-> prdata == $past(pwdata))
    else $error("key register readback mismatch");

endmodule

bind ghash_accumulator ghacc_checker u_ghacc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
